### sv/irc_tok_pkg.sv
// shared types and character codes of the irc line tokenizer
package irc_tok_pkg;

  localparam int unsigned POS_W = 9;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_READ = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    RES_TOKEN    = 2'd0,
    RES_READ     = 2'd1,
    RES_OVERFLOW = 2'd2
  } res_kind_e;

  typedef enum logic [1:0] {
    TOK_ORIGIN  = 2'd0,
    TOK_COMMAND = 2'd1,
    TOK_ARG     = 2'd2,
    TOK_EMPTY   = 2'd3
  } token_kind_e;

endpackage

### sv/irc_tok_if.sv
// request and result channel interfaces of the irc line tokenizer
interface irc_tok_req_if import irc_tok_pkg::*; ();
  logic              valid;
  logic              ready;
  req_type_e         req_type;
  logic [BYTE_W-1:0] byte_in;
  logic [POS_W-1:0]  read_addr;

  modport source (output valid, req_type, byte_in, read_addr, input ready);
  modport sink   (input valid, req_type, byte_in, read_addr, output ready);
endinterface

interface irc_tok_res_if import irc_tok_pkg::*; ();
  logic              valid;
  logic              ready;
  res_kind_e         res_kind;
  token_kind_e       token_kind;
  logic [IDX_W-1:0]  token_index;
  logic [POS_W-1:0]  token_start;
  logic [POS_W-1:0]  token_length;
  logic [BYTE_W-1:0] read_data;
  logic              last;

  modport source (output valid, res_kind, token_kind, token_index, token_start,
                  token_length, read_data, last, input ready);
  modport sink   (input valid, res_kind, token_kind, token_index, token_start,
                  token_length, read_data, last, output ready);
endinterface

### sv/irc_line_tokenizer_top.sv
// irc line tokenizer: byte parser, line store, argument offset store, token report
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    req_type, byte_in, read_addr
//   res_o    out  valid/ready    res_kind, token_kind, token_index, token_start,
//                                token_length, read_data, last
//
// a line byte is parsed and written to the line store at the edge that accepts it, so
// ready is back the next cycle unless a result still waits or an LF starts the report
// a read request passes the registered read port of the line store, then ST_RDWAIT
// at LF the report walk makes one arg offset store read per argument
// reset clears the parser and report control; both stores keep their contents and
// hold undefined data until written, so there is no clearing pass
// a stalled result register holds the block in place; new requests wait for it
module irc_line_tokenizer_top import irc_tok_pkg::*; #(
  parameter int unsigned LINE_BYTES = 512,
  parameter int unsigned ARG_SLOTS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  irc_tok_req_if.sink        req_i,
  irc_tok_res_if.source      res_o
);

  // widths derived from the store depths
  localparam int unsigned AW = $clog2(LINE_BYTES);
  localparam int unsigned SW = (ARG_SLOTS > 2) ? $clog2(ARG_SLOTS) : 1;
  localparam int unsigned NW = $clog2(ARG_SLOTS + 1);
  localparam int unsigned CW = (AW > POS_W) ? AW : POS_W;
  localparam int unsigned XW = (NW > IDX_W) ? NW : IDX_W;

  // parser states
  typedef enum logic [2:0] {
    PS_BOM, PS_ORG, PS_SPC0, PS_CMD, PS_SPC1, PS_ARG, PS_TAIL, PS_EOL
  } ps_e;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE, ST_RDWAIT, ST_NEXT, ST_ADV, ST_LAST
  } st_e;

  typedef struct packed {
    logic              valid;
    res_kind_e         kind;
    token_kind_e       tkind;
    logic [IDX_W-1:0]  idx;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  len;
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

  function automatic logic [POS_W-1:0] pos9(logic [AW-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    return w[POS_W-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [POS_W-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    return w[AW-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx4(logic [NW-1:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    return w[IDX_W-1:0];
  endfunction

  // control and line state
  st_e               st_q, st_d;
  ps_e               pst_q, pst_d;
  logic [AW-1:0]     fill_q, fill_d;
  logic              org_q, org_d;
  logic              cmd_q, cmd_d;
  logic [AW-1:0]     cmd_off_q, cmd_off_d;
  logic [NW-1:0]     argn_q, argn_d;
  logic              tail_q, tail_d;
  logic              rd_oob_q, rd_oob_d;

  // report walk
  logic              org_pend_q, org_pend_d;
  logic              cmd_pend_q, cmd_pend_d;
  logic [NW-1:0]     aptr_q, aptr_d;
  logic              have_cur_q, have_cur_d;
  token_kind_e       cur_kind_q, cur_kind_d;
  logic [IDX_W-1:0]  cur_idx_q, cur_idx_d;
  logic [AW-1:0]     cur_start_q, cur_start_d;
  token_kind_e       nxt_kind_q, nxt_kind_d;
  logic [IDX_W-1:0]  nxt_idx_q, nxt_idx_d;
  logic [AW-1:0]     nxt_start_q, nxt_start_d;
  logic              nxt_mem_q, nxt_mem_d;

  // result register
  res_t              res_q, res_d;

  // line store ports
  logic [BYTE_W-1:0] line_mem [LINE_BYTES];
  logic              lm_we, lm_re;
  logic [AW-1:0]     lm_waddr, lm_raddr;
  logic [BYTE_W-1:0] lm_wdata, lm_rdata_q;

  // argument offset store ports
  logic [AW-1:0]     arg_mem [ARG_SLOTS];
  logic              am_we, am_re;
  logic [SW-1:0]     am_waddr, am_raddr;
  logic [AW-1:0]     am_wdata, am_rdata_q;

  logic              out_free;
  logic              req_fire;

  // the result slot is free when empty or drained this cycle
  assign out_free = !res_q.valid || res_o.ready;
  assign req_i.ready = (st_q == ST_IDLE) && out_free;
  assign req_fire = req_i.valid && req_i.ready;

  assign res_o.valid        = res_q.valid;
  assign res_o.res_kind     = res_q.kind;
  assign res_o.token_kind   = res_q.tkind;
  assign res_o.token_index  = res_q.idx;
  assign res_o.token_start  = res_q.start;
  assign res_o.token_length = res_q.len;
  assign res_o.read_data    = res_q.data;
  assign res_o.last         = res_q.last;

  always_comb begin
    logic [BYTE_W-1:0] c;
    logic              app, app_close, clr, rpt, ovf, sarg, scmd, org_after;
    logic [AW-1:0]     nstart;

    c         = req_i.byte_in;
    app       = 1'b0;
    app_close = 1'b0;
    clr       = 1'b0;
    rpt       = 1'b0;
    ovf       = 1'b0;
    sarg      = 1'b0;
    scmd      = 1'b0;
    org_after = 1'b0;
    nstart    = nxt_mem_q ? am_rdata_q : nxt_start_q;

    st_d        = st_q;
    pst_d       = pst_q;
    fill_d      = fill_q;
    org_d       = org_q;
    cmd_d       = cmd_q;
    cmd_off_d   = cmd_off_q;
    argn_d      = argn_q;
    tail_d      = tail_q;
    rd_oob_d    = rd_oob_q;
    org_pend_d  = org_pend_q;
    cmd_pend_d  = cmd_pend_q;
    aptr_d      = aptr_q;
    have_cur_d  = have_cur_q;
    cur_kind_d  = cur_kind_q;
    cur_idx_d   = cur_idx_q;
    cur_start_d = cur_start_q;
    nxt_kind_d  = nxt_kind_q;
    nxt_idx_d   = nxt_idx_q;
    nxt_start_d = nxt_start_q;
    nxt_mem_d   = nxt_mem_q;

    res_d = res_q;
    if (res_o.ready) begin
      res_d.valid = 1'b0;
    end

    lm_we    = 1'b0;
    lm_waddr = fill_q;
    lm_wdata = c;
    lm_re    = 1'b0;
    lm_raddr = addr_of(req_i.read_addr);
    am_we    = 1'b0;
    am_waddr = argn_q[SW-1:0];
    am_wdata = fill_q;
    am_re    = 1'b0;
    am_raddr = aptr_q[SW-1:0];

    case (st_q)
      ST_IDLE: begin
        if (req_fire && req_i.req_type == REQ_READ) begin
          lm_re    = 1'b1;
          rd_oob_d = !({23'd0, req_i.read_addr} < 32'(LINE_BYTES));
          st_d     = ST_RDWAIT;
        end else if (req_fire) begin
          // byte parser
          case (pst_q)
            PS_BOM, PS_SPC0: begin
              if (c == CHAR_COLON && pst_q == PS_BOM) begin
                pst_d = PS_ORG;
                org_d = 1'b1;
              end else if (c == CHAR_SPACE) begin
                pst_d = pst_q;
              end else if (c == CHAR_CR) begin
                pst_d = PS_EOL;
              end else if (c == CHAR_LF) begin
                clr = 1'b1;
              end else begin
                pst_d = PS_CMD;
                scmd  = 1'b1;
                app   = 1'b1;
              end
            end
            PS_ORG: begin
              if (c == CHAR_SPACE) begin
                pst_d     = PS_SPC0;
                app       = 1'b1;
                app_close = 1'b1;
              end else if (c == CHAR_CR) begin
                pst_d     = PS_EOL;
                app       = 1'b1;
                app_close = 1'b1;
              end else if (c == CHAR_LF) begin
                clr = 1'b1;
              end else begin
                app = 1'b1;
              end
            end
            PS_CMD, PS_ARG: begin
              if (c == CHAR_SPACE) begin
                pst_d     = PS_SPC1;
                app       = 1'b1;
                app_close = 1'b1;
              end else if (c == CHAR_CR) begin
                pst_d     = PS_EOL;
                app       = 1'b1;
                app_close = 1'b1;
              end else if (c == CHAR_LF) begin
                rpt = 1'b1;
              end else begin
                app = 1'b1;
              end
            end
            PS_SPC1: begin
              if (c == CHAR_SPACE) begin
                pst_d = PS_SPC1;
              end else if (c == CHAR_CR) begin
                pst_d = PS_EOL;
              end else if (c == CHAR_LF) begin
                rpt = 1'b1;
              end else if (argn_q >= NW'(ARG_SLOTS)) begin
                ovf = 1'b1;
              end else begin
                sarg = 1'b1;
                if (c == CHAR_COLON) begin
                  pst_d = PS_TAIL;
                end else begin
                  pst_d = PS_ARG;
                  app   = 1'b1;
                end
              end
            end
            PS_TAIL: begin
              if (c == CHAR_CR) begin
                pst_d     = PS_EOL;
                app       = 1'b1;
                app_close = 1'b1;
              end else if (c == CHAR_LF) begin
                rpt = 1'b1;
              end else begin
                app = 1'b1;
              end
            end
            PS_EOL: begin
              if (c == CHAR_CR) begin
                pst_d = PS_EOL;
              end else if (c == CHAR_LF) begin
                rpt = 1'b1;
              end else begin
                clr       = 1'b1;
                org_after = (c == CHAR_COLON);
              end
            end
            default: begin
              clr = 1'b1;
            end
          endcase

          if (scmd) begin
            cmd_d     = 1'b1;
            cmd_off_d = fill_q;
          end
          if (sarg) begin
            am_we  = 1'b1;
            argn_d = argn_q + NW'(1);
            tail_d = 1'b0;
          end
          if (app) begin
            lm_we    = 1'b1;
            lm_wdata = app_close ? '0 : c;
            fill_d   = fill_q + AW'(1);
            tail_d   = app_close;
            // buffer full: drop the line without a result
            if (fill_q == AW'(LINE_BYTES - 2)) begin
              clr = 1'b1;
            end
          end
          if (rpt) begin
            if (argn_q >= NW'(ARG_SLOTS)) begin
              ovf = 1'b1;
            end else if (!org_q && !cmd_q && argn_q == '0) begin
              res_d = '{valid: 1'b1, kind: RES_TOKEN, tkind: TOK_EMPTY, idx: '0,
                        start: '0, len: '0, data: '0, last: 1'b1};
              clr   = 1'b1;
            end else begin
              org_pend_d = org_q;
              cmd_pend_d = cmd_q;
              aptr_d     = '0;
              have_cur_d = 1'b0;
              st_d       = ST_NEXT;
            end
          end
          if (ovf) begin
            res_d = '{valid: 1'b1, kind: RES_OVERFLOW, tkind: TOK_ORIGIN, idx: '0,
                      start: '0, len: '0, data: '0, last: 1'b1};
            clr   = 1'b1;
          end
        end
      end

      ST_RDWAIT: begin
        if (out_free) begin
          res_d = '{valid: 1'b1, kind: RES_READ, tkind: TOK_ORIGIN, idx: '0,
                    start: '0, len: '0, data: rd_oob_q ? '0 : lm_rdata_q, last: 1'b1};
          st_d  = ST_IDLE;
        end
      end

      // pick the next token: origin, command, then arguments from the offset store
      ST_NEXT: begin
        if (org_pend_q) begin
          org_pend_d  = 1'b0;
          nxt_kind_d  = TOK_ORIGIN;
          nxt_idx_d   = '0;
          nxt_start_d = '0;
          nxt_mem_d   = 1'b0;
          st_d        = ST_ADV;
        end else if (cmd_pend_q) begin
          cmd_pend_d  = 1'b0;
          nxt_kind_d  = TOK_COMMAND;
          nxt_idx_d   = '0;
          nxt_start_d = cmd_off_q;
          nxt_mem_d   = 1'b0;
          st_d        = ST_ADV;
        end else if (aptr_q < argn_q) begin
          am_re      = 1'b1;
          nxt_kind_d = TOK_ARG;
          nxt_idx_d  = idx4(aptr_q);
          nxt_mem_d  = 1'b1;
          aptr_d     = aptr_q + NW'(1);
          st_d       = ST_ADV;
        end else begin
          st_d = ST_LAST;
        end
      end

      // the next start closes the current token
      ST_ADV: begin
        if (!have_cur_q || out_free) begin
          if (have_cur_q) begin
            res_d = '{valid: 1'b1, kind: RES_TOKEN, tkind: cur_kind_q, idx: cur_idx_q,
                      start: pos9(cur_start_q),
                      len: pos9(nstart - cur_start_q - AW'(1)), data: '0, last: 1'b0};
          end
          have_cur_d  = 1'b1;
          cur_kind_d  = nxt_kind_q;
          cur_idx_d   = nxt_idx_q;
          cur_start_d = nstart;
          st_d        = ST_NEXT;
        end
      end

      ST_LAST: begin
        if (out_free) begin
          res_d = '{valid: 1'b1, kind: RES_TOKEN, tkind: cur_kind_q, idx: cur_idx_q,
                    start: pos9(cur_start_q),
                    len: pos9(fill_q - cur_start_q - AW'(tail_q)), data: '0, last: 1'b1};
          clr   = 1'b1;
          st_d  = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase

    // drop the line state, then start a new origin after CR where asked
    if (clr) begin
      pst_d     = PS_BOM;
      fill_d    = '0;
      org_d     = 1'b0;
      cmd_d     = 1'b0;
      cmd_off_d = '0;
      argn_d    = '0;
      tail_d    = 1'b0;
    end
    if (org_after) begin
      pst_d = PS_ORG;
      org_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pst_q       <= PS_BOM;
      fill_q      <= '0;
      org_q       <= 1'b0;
      cmd_q       <= 1'b0;
      cmd_off_q   <= '0;
      argn_q      <= '0;
      tail_q      <= 1'b0;
      rd_oob_q    <= 1'b0;
      org_pend_q  <= 1'b0;
      cmd_pend_q  <= 1'b0;
      aptr_q      <= '0;
      have_cur_q  <= 1'b0;
      cur_kind_q  <= TOK_ORIGIN;
      cur_idx_q   <= '0;
      cur_start_q <= '0;
      nxt_kind_q  <= TOK_ORIGIN;
      nxt_idx_q   <= '0;
      nxt_start_q <= '0;
      nxt_mem_q   <= 1'b0;
      res_q       <= '{valid: 1'b0, kind: RES_TOKEN, tkind: TOK_ORIGIN, idx: '0,
                       start: '0, len: '0, data: '0, last: 1'b0};
    end else begin
      st_q        <= st_d;
      pst_q       <= pst_d;
      fill_q      <= fill_d;
      org_q       <= org_d;
      cmd_q       <= cmd_d;
      cmd_off_q   <= cmd_off_d;
      argn_q      <= argn_d;
      tail_q      <= tail_d;
      rd_oob_q    <= rd_oob_d;
      org_pend_q  <= org_pend_d;
      cmd_pend_q  <= cmd_pend_d;
      aptr_q      <= aptr_d;
      have_cur_q  <= have_cur_d;
      cur_kind_q  <= cur_kind_d;
      cur_idx_q   <= cur_idx_d;
      cur_start_q <= cur_start_d;
      nxt_kind_q  <= nxt_kind_d;
      nxt_idx_q   <= nxt_idx_d;
      nxt_start_q <= nxt_start_d;
      nxt_mem_q   <= nxt_mem_d;
      res_q       <= res_d;
    end
  end

  // line store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (lm_we) begin
      line_mem[lm_waddr] <= lm_wdata;
    end
    if (lm_re) begin
      lm_rdata_q <= line_mem[lm_raddr];
    end
  end

  // argument offset store
  always_ff @(posedge clk_i) begin
    if (am_we) begin
      arg_mem[am_waddr] <= am_wdata;
    end
    if (am_re) begin
      am_rdata_q <= arg_mem[am_raddr];
    end
  end

  // the full-buffer drop keeps the fill count below the last position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != AW'(LINE_BYTES - 1))
    else $error("fill count reached the last buffer position");

  // argument count never passes the slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    argn_q <= NW'(ARG_SLOTS))
    else $error("argument count beyond slot count");

  // an accepted read request is followed in the next cycle by ST_RDWAIT for the line store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.req_type == REQ_READ) |=> (st_q == ST_RDWAIT))
    else $error("read request did not wait for store data");

  // the report walk never runs past the stored arguments
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_NEXT || st_q == ST_ADV || st_q == ST_LAST) |-> (aptr_q <= argn_q))
    else $error("report walk beyond argument count");

endmodule
